>>> src/qpe_pkg.sv
// types, constants and helpers shared by the quoted-printable encoder
package qpe_pkg;

  localparam int CHAR_W    = 8;
  localparam int RUN_MAX   = 6;
  localparam int RUN_IDX_W = 3;

  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_EQ  = 8'h3D;

  localparam logic [CHAR_W-1:0] LIT_LO_A = 8'd33;
  localparam logic [CHAR_W-1:0] LIT_HI_A = 8'd60;
  localparam logic [CHAR_W-1:0] LIT_LO_B = 8'd62;
  localparam logic [CHAR_W-1:0] LIT_HI_B = 8'd126;

  localparam logic [CHAR_W-1:0] LINE_LIMIT_RESET = 8'd76;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LINE_LIMIT = 3'd0;

  typedef struct packed {
    logic [CHAR_W-1:0] data_byte;
    logic [CHAR_W-1:0] next_byte;
    logic              final_byte;
  } qpe_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
  } qpe_out_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][CHAR_W-1:0] chars;
    logic [RUN_IDX_W-1:0]           count;
  } qpe_run_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'h0, nib};
    end else begin
      res = 8'h37 + {4'h0, nib};
    end
    return res;
  endfunction

endpackage

>>> src/qpe_decode.sv
// classifies one byte and builds its run of output characters
module qpe_decode
  import qpe_pkg::*;
(
  input  qpe_in_t           item,
  input  logic [CHAR_W-1:0] line_length,
  input  logic [CHAR_W-1:0] line_limit,
  output qpe_run_t          run,
  output logic [CHAR_W-1:0] line_length_nxt
);

  logic [CHAR_W-1:0] c;
  logic              ends_line;
  logic              is_print;
  logic              is_ws;
  logic              is_eol;
  logic              literal;
  logic              encoded;
  logic [CHAR_W:0]   need;
  logic              brk;
  logic [CHAR_W-1:0] p0;
  logic [CHAR_W-1:0] p1;
  logic [CHAR_W-1:0] p2;
  logic [CHAR_W-1:0] base;

  always_comb begin
    c         = item.data_byte;
    ends_line = item.final_byte || item.next_byte == CH_LF || item.next_byte == CH_CR;
    is_print  = (c >= LIT_LO_A && c <= LIT_HI_A) || (c >= LIT_LO_B && c <= LIT_HI_B);
    is_ws     = c == CH_SP || c == CH_TAB;
    is_eol    = c == CH_CR || c == CH_LF;
    literal   = is_print || (is_ws && !ends_line);
    encoded   = !literal && !is_eol;
    need      = encoded ? 9'd3 : 9'd1;
    brk       = !is_eol && (({1'b0, line_length} + need) >= {1'b0, line_limit});

    p0 = encoded ? CH_EQ : c;
    p1 = hex_char(c[7:4]);
    p2 = hex_char(c[3:0]);

    run.chars = '0;
    if (brk) begin
      run.chars[0] = CH_EQ;
      run.chars[1] = CH_CR;
      run.chars[2] = CH_LF;
      run.chars[3] = p0;
      run.chars[4] = p1;
      run.chars[5] = p2;
    end else begin
      run.chars[0] = p0;
      run.chars[1] = p1;
      run.chars[2] = p2;
    end
    run.count = (brk ? 3'd3 : 3'd0) + (encoded ? 3'd3 : 3'd1);

    base = brk ? '0 : line_length;
    if (is_eol) begin
      line_length_nxt = '0;
    end else begin
      line_length_nxt = base + need[CHAR_W-1:0];
    end
  end

endmodule

>>> src/quoted_printable_encoder.sv
// quoted-printable encoder top level: input stage, run register, config port
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | in_data  (qpe_in_t)
//  out     | output    | out_valid / out_ready | out_data (qpe_out_t)
//  cfg     | input     | psel/penable/pwrite   | paddr, pwdata, prdata
//
// one output word per cycle while out_ready is high; an input word gives 1, 3, 4
// or 6 words, holding the output side until all have left; the run register sets the pace
// an accepted input word goes to the input register, then the run register, then out
// with out_ready high, a byte with one output word lets a new input word in every cycle
// synchronous active-low reset clears valids, line length and sets line_limit to 76
// stalls on out_ready back up through the input register to in_ready
module quoted_printable_encoder
  import qpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  qpe_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output qpe_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  qpe_in_t              s1_r;
  logic                 run_valid_r;
  logic                 run_valid_nxt;
  qpe_run_t             run_r;
  qpe_run_t             run_dec;
  logic [RUN_IDX_W-1:0] run_idx_r;
  logic [RUN_IDX_W-1:0] run_idx_nxt;
  logic [CHAR_W-1:0]    line_length_r;
  logic [CHAR_W-1:0]    line_length_nxt;
  logic [CHAR_W-1:0]    line_length_dec;
  logic [CHAR_W-1:0]    line_limit_r;
  logic [CHAR_W-1:0]    line_limit_nxt;
  logic                 run_last;
  logic                 run_free;
  logic                 s1_move;
  logic                 cfg_wr;

  qpe_decode u_decode (
    .item            (s1_r),
    .line_length     (line_length_r),
    .line_limit      (line_limit_r),
    .run             (run_dec),
    .line_length_nxt (line_length_dec)
  );

  assign run_last  = run_idx_r == (run_r.count - 3'd1);
  assign run_free  = !run_valid_r || (out_ready && run_last);
  assign s1_move   = s1_valid_r && run_free;
  assign in_ready  = !s1_valid_r || run_free;

  assign out_valid         = run_valid_r;
  assign out_data.out_char = run_r.chars[run_idx_r];
  assign out_data.run_last = run_last;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LINE_LIMIT) ? {{(CFG_DATA_W-CHAR_W){1'b0}}, line_limit_r} : '0;

  always_comb begin
    s1_valid_nxt    = s1_valid_r;
    run_valid_nxt   = run_valid_r;
    run_idx_nxt     = run_idx_r;
    line_length_nxt = line_length_r;
    line_limit_nxt  = line_limit_r;
    if (run_free) begin
      run_valid_nxt = s1_valid_r;
    end
    if (s1_move) begin
      run_idx_nxt     = '0;
      line_length_nxt = line_length_dec;
    end else if (run_valid_r && out_ready) begin
      run_idx_nxt = run_idx_r + 3'd1;
    end
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    if (cfg_wr && paddr == ADDR_LINE_LIMIT) begin
      line_limit_nxt = pwdata[CHAR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      run_valid_r   <= 1'b0;
      run_idx_r     <= '0;
      line_length_r <= '0;
      line_limit_r  <= LINE_LIMIT_RESET;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      run_valid_r   <= run_valid_nxt;
      run_idx_r     <= run_idx_nxt;
      line_length_r <= line_length_nxt;
      line_limit_r  <= line_limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (s1_move) begin
      run_r <= run_dec;
    end
  end

`ifndef SYNTH
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> run_idx_r < run_r.count)
    else $error("run index past run length");

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> (run_r.count == 3'd1 || run_r.count == 3'd3 ||
                     run_r.count == 3'd4 || run_r.count == 3'd6))
    else $error("illegal run length");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.run_last) |=> out_valid)
    else $error("run dropped before its last word");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted word lost from input register");

  a_held_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |=> (s1_valid_r && $stable(s1_r)))
    else $error("input register changed while waiting");
`endif

endmodule

>>> sim/quoted_printable_encoder_tb.sv
// testbench for the quoted-printable encoder: random stream stimulus, encoding predictor, checks
module quoted_printable_encoder_tb
  import qpe_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam string HEX_DIGITS = "0123456789ABCDEF";

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  qpe_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  qpe_out_t              out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  quoted_printable_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  qpe_in_t    text_words[$];
  qpe_out_t   encoded_chars[$];
  logic [7:0] line_len_model;
  logic [7:0] line_limit_model;

  int in_gap_max = 0;
  int out_gap_max = 0;
  int in_gap = 0;
  int out_hold = 0;
  int err_count = 0;
  int words_in = 0;
  int words_out = 0;
  int limit_writes = 0;
  int stall_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // expected output characters for one accepted text byte
  function automatic void encode_byte(input qpe_in_t w);
    logic [7:0] run_q[$];
    logic       ends_line;
    logic       plain;
    logic       line_end;
    int         need;
    qpe_out_t   e;
    ends_line = w.final_byte || w.next_byte == CH_LF || w.next_byte == CH_CR;
    plain = (w.data_byte >= LIT_LO_A && w.data_byte <= LIT_HI_A) ||
            (w.data_byte >= LIT_LO_B && w.data_byte <= LIT_HI_B) ||
            ((w.data_byte == CH_SP || w.data_byte == CH_TAB) && !ends_line);
    line_end = w.data_byte == CH_CR || w.data_byte == CH_LF;
    need = plain ? 1 : 3;
    if (!line_end && int'(line_len_model) + need >= int'(line_limit_model)) begin
      run_q.insert(run_q.size(), CH_EQ);
      run_q.insert(run_q.size(), CH_CR);
      run_q.insert(run_q.size(), CH_LF);
      line_len_model = 8'd0;
    end
    if (line_end) begin
      run_q.insert(run_q.size(), w.data_byte);
      line_len_model = 8'd0;
    end else if (plain) begin
      run_q.insert(run_q.size(), w.data_byte);
      line_len_model = line_len_model + 8'd1;
    end else begin
      run_q.insert(run_q.size(), CH_EQ);
      run_q.insert(run_q.size(), HEX_DIGITS[w.data_byte[7:4]]);
      run_q.insert(run_q.size(), HEX_DIGITS[w.data_byte[3:0]]);
      line_len_model = line_len_model + 8'd3;
    end
    foreach (run_q[i]) begin
      e.out_char = run_q[i];
      e.run_last = (i == run_q.size() - 1);
      encoded_chars.insert(encoded_chars.size(), e);
    end
  endfunction

  function automatic void add_word(input logic [7:0] d, input logic [7:0] nx,
                                   input logic fin);
    qpe_in_t w;
    w.data_byte = d;
    w.next_byte = nx;
    w.final_byte = fin;
    text_words.insert(text_words.size(), w);
  endfunction

  // text with a real lookahead; percentages pick encoded bytes and line ends
  function automatic void queue_text(input int len, input int nl_pct, input int enc_pct);
    logic [7:0] txt[$];
    int         r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < enc_pct) begin
        if ($urandom_range(0, 3) == 0) txt.insert(txt.size(), CH_EQ);
        else if ($urandom_range(0, 1) == 1)
          txt.insert(txt.size(), 8'($urandom_range(127, 255)));
        else txt.insert(txt.size(), 8'($urandom_range(0, 31)));
      end else if (r < enc_pct + nl_pct) begin
        txt.insert(txt.size(), $urandom_range(0, 1) ? CH_CR : CH_LF);
      end else if (r < enc_pct + nl_pct + 15) begin
        txt.insert(txt.size(), $urandom_range(0, 1) ? CH_SP : CH_TAB);
      end else begin
        txt.insert(txt.size(), 8'($urandom_range(33, 126)));
      end
    end
    foreach (txt[i]) begin
      if (i == txt.size() - 1) add_word(txt[i], 8'($urandom), 1'b1);
      else add_word(txt[i], txt[i+1], 1'b0);
    end
  endfunction

  function automatic void queue_noise(input int count);
    for (int i = 0; i < count; i++) begin
      add_word(8'($urandom), 8'($urandom), 1'($urandom));
    end
  endfunction

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LINE_LIMIT) begin
      line_limit_model = value[7:0];
      limit_writes++;
    end
  endtask

  task automatic cfg_check_limit();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_LINE_LIMIT;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[7:0] !== line_limit_model) begin
      $display("%0t: line_limit read expected %0d actual %0d", $time,
               line_limit_model, prdata[7:0]);
      err_count++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (text_words.size() != 0 || in_valid || encoded_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_gaps(input int in_max, input int out_max);
    in_gap_max = in_max;
    out_gap_max = out_max;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        encode_byte(in_data);
        words_in++;
        in_gap = $urandom_range(0, in_gap_max);
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (text_words.size() != 0) begin
          in_data <= text_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    qpe_out_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        words_out++;
        if (encoded_chars.size() == 0) begin
          $display("%0t: unexpected word char %h last %b", $time,
                   out_data.out_char, out_data.run_last);
          err_count++;
        end else begin
          e = encoded_chars.pop_front();
          if (out_data.out_char !== e.out_char) begin
            $display("%0t: out_char expected %h actual %h", $time,
                     e.out_char, out_data.out_char);
            err_count++;
          end
          if (out_data.run_last !== e.run_last) begin
            $display("%0t: run_last expected %b actual %b", $time,
                     e.run_last, out_data.run_last);
            err_count++;
          end
        end
        out_hold = $urandom_range(0, out_gap_max);
      end
      if (out_hold != 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    line_limit_model = LINE_LIMIT_RESET;
    line_len_model = 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    cfg_check_limit();

    // literals, encodings, whitespace and line ends
    set_gaps(19, 19);
    add_word(8'd65, 8'd66, 1'b0);
    add_word(LIT_LO_A, 8'h00, 1'b0);
    add_word(LIT_HI_A, 8'hFF, 1'b0);
    add_word(LIT_LO_B, 8'd65, 1'b0);
    add_word(LIT_HI_B, 8'd65, 1'b0);
    add_word(CH_EQ, 8'd65, 1'b0);
    add_word(8'h00, 8'h00, 1'b0);
    add_word(8'hFF, 8'hFF, 1'b0);
    add_word(8'h7F, 8'd65, 1'b0);
    add_word(8'h80, 8'd65, 1'b0);
    add_word(8'd32, 8'd65, 1'b0);
    add_word(CH_SP, 8'd120, 1'b0);
    add_word(CH_TAB, 8'd120, 1'b0);
    add_word(CH_SP, CH_CR, 1'b0);
    add_word(CH_TAB, CH_LF, 1'b0);
    add_word(CH_SP, CH_LF, 1'b0);
    add_word(CH_TAB, CH_CR, 1'b0);
    add_word(CH_SP, 8'd97, 1'b1);
    add_word(CH_TAB, 8'hFF, 1'b1);
    add_word(CH_CR, CH_LF, 1'b0);
    add_word(CH_LF, 8'd65, 1'b0);
    add_word(8'd90, 8'h00, 1'b1);
    drain();

    // minimum sensible limit, back to back
    cfg_write(ADDR_LINE_LIMIT, 32'd4);
    cfg_check_limit();
    set_gaps(0, 0);
    queue_text(15, 8, 30);
    queue_text(15, 8, 30);
    drain();

    // widest limit: long text of mostly encoded bytes without line ends, then literals
    cfg_write(ADDR_LINE_LIMIT, 32'hFFFF_FFFF);
    cfg_check_limit();
    set_gaps(19, 0);
    queue_text(95, 0, 90);
    for (int i = 0; i < 20; i++) add_word(8'd113, 8'd113, 1'b0);
    drain();

    // limits below 4, lowered mid-line
    cfg_write(ADDR_LINE_LIMIT, 32'd0);
    cfg_check_limit();
    set_gaps(0, 19);
    queue_text(12, 10, 30);
    drain();
    cfg_write(ADDR_LINE_LIMIT, 32'd1);
    set_gaps(19, 19);
    queue_text(12, 10, 30);
    drain();
    cfg_write(ADDR_LINE_LIMIT, 32'd3);
    cfg_check_limit();
    set_gaps(0, 0);
    queue_text(12, 10, 30);
    drain();

    // upper data bits ignored, writes to unused addresses ignored
    cfg_write(ADDR_LINE_LIMIT, 32'hDEAD_BE10);
    cfg_write(3'd4, $urandom);
    cfg_write(3'd7, 32'hFFFF_FFFF);
    cfg_check_limit();
    set_gaps(19, 19);
    queue_noise(12);
    queue_text(13, 10, 30);
    drain();

    // random limit
    cfg_write(ADDR_LINE_LIMIT, $urandom);
    cfg_check_limit();
    set_gaps(19, 19);
    queue_text(10, 10, 30);
    queue_noise(5);
    queue_text(10, 10, 30);
    drain();

    repeat (8) @(posedge clk);
    $display("%0d text bytes in, %0d encoded characters out", words_in, words_out);
    $display("%0d line_limit writes, incl. 0, 1, 3, 4, 255 and lowered mid-line",
             limit_writes);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
src/qpe_pkg.sv
src/qpe_decode.sv
src/quoted_printable_encoder.sv
sim/quoted_printable_encoder_tb.sv
